/* design/clis_pkg.sv */
package clis_pkg;

  localparam int VALUE_W = 32;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 2;
  localparam int POS_W   = 4;
  localparam int FILL_W  = 5;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;
    logic [FILL_W-1:0] fill_count;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_DONE
  } state_t;

endpackage

/* design/clis_if.sv */
interface clis_req_if;
  logic                               valid;
  logic                               ready;
  logic [clis_pkg::OP_W-1:0]          op;
  logic signed [clis_pkg::VALUE_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink (input valid, input op, input value, output ready);
endinterface

interface clis_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [clis_pkg::STAT_W-1:0] status;
  logic [clis_pkg::POS_W-1:0]  position;
  logic [clis_pkg::FILL_W-1:0] fill_count;

  modport source (output valid, output status, output position, output fill_count, input ready);
  modport sink (input valid, input status, input position, input fill_count, output ready);
endinterface

/* design/compact_list_insert_search_remove_top.sv */
// packed list of signed 32-bit values with first-match search and remove
// in_req carries a request (op, value); out_rsp returns one result per
// request (status, position, fill_count); both are valid/ready channels
// the entries sit in a one-port-read, one-port-write synchronous memory
// each request kind passes from the accepting edge to out_rsp.valid so:
// insert, unused op code, or any request on an empty list: straight to done
// search: scan from index 0 up to the first hit or the end of the list,
//   one entry compared per cycle behind a registered memory read
// remove: scan up to the match, then on a hit one entry moved per cycle
//   and one closing step; a miss ends with the scan
// one request at a time; the next request is taken the cycle after the
// result has moved into the output register, so a new request is never
// taken while the last one is still in the controller
// a stalled out_rsp holds its result; a second finished result waits in
// the controller until the output register frees up, and in_req stalls
// reset empties the list (count zero); memory contents are not cleared
module compact_list_insert_search_remove_top #(
  parameter int CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  clis_req_if.sink          in_req,
  clis_rsp_if.source        out_rsp
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  clis_pkg::req_t req;
  clis_pkg::res_t res;
  clis_pkg::res_t out_r;
  logic           req_ready;
  logic           res_valid;
  logic           res_taken;
  logic           out_valid_r;

  logic                         mem_wen;
  logic [IDX_W-1:0]             mem_waddr;
  logic [clis_pkg::VALUE_W-1:0] mem_wdata;
  logic                         mem_ren;
  logic [IDX_W-1:0]             mem_raddr;
  logic [clis_pkg::VALUE_W-1:0] mem_rdata;

  assign req.op       = in_req.op;
  assign req.value    = in_req.value;
  assign in_req.ready = req_ready;

  clis_ctrl #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_req.valid),
    .req       (req),
    .req_ready (req_ready),
    .res_valid (res_valid),
    .res       (res),
    .res_taken (res_taken),
    .mem_wen   (mem_wen),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_ren   (mem_ren),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  clis_mem #(
    .DEPTH  (CAPACITY),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .wen   (mem_wen),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .ren   (mem_ren),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register
  assign res_taken = !out_valid_r || out_rsp.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_taken) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_taken) begin
      out_r <= res;
    end
  end

  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.status     = out_r.status;
  assign out_rsp.position   = out_r.position;
  assign out_rsp.fill_count = out_r.fill_count;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.valid && req_ready |=> !req_ready)
    else $error("request accepted while another is in flight");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_taken |=> out_valid_r)
    else $error("finished result did not reach the output register");

  a_pos_zero_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.status == clis_pkg::STAT_OK || out_r.position == '0))
    else $error("nonzero position on a failed request");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wen && mem_ren |-> mem_waddr != mem_raddr)
    else $error("read and write to the same entry in one cycle");

endmodule

/* design/clis_mem.sv */
module clis_mem #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic                         clk,
  input  logic                         wen,
  input  logic [ADDR_W-1:0]            waddr,
  input  logic [clis_pkg::VALUE_W-1:0] wdata,
  input  logic                         ren,
  input  logic [ADDR_W-1:0]            raddr,
  output logic [clis_pkg::VALUE_W-1:0] rdata
);

  logic [clis_pkg::VALUE_W-1:0] mem [DEPTH];
  logic [clis_pkg::VALUE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ren) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/clis_ctrl.sv */
module clis_ctrl #(
  parameter int CAPACITY = 16,
  parameter int IDX_W    = 4,
  parameter int CNT_W    = 5
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         req_valid,
  input  clis_pkg::req_t               req,
  output logic                         req_ready,
  output logic                         res_valid,
  output clis_pkg::res_t               res,
  input  logic                         res_taken,
  output logic                         mem_wen,
  output logic [IDX_W-1:0]             mem_waddr,
  output logic [clis_pkg::VALUE_W-1:0] mem_wdata,
  output logic                         mem_ren,
  output logic [IDX_W-1:0]             mem_raddr,
  input  logic [clis_pkg::VALUE_W-1:0] mem_rdata
);

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  clis_pkg::state_t             state_r, state_nxt;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic [CNT_W-1:0]             idx_r, idx_nxt;
  logic [IDX_W-1:0]             at_r, at_nxt;
  logic [clis_pkg::OP_W-1:0]    op_r, op_nxt;
  logic [clis_pkg::VALUE_W-1:0] val_r, val_nxt;
  clis_pkg::res_t               res_r, res_nxt;

  logic [CNT_W-1:0] idx_inc;
  logic [CNT_W:0]   idx_inc2;
  logic             more_1;
  logic             more_2;
  logic             hit;
  logic             accept;

  assign idx_inc  = idx_r + CNT_W'(1);
  assign idx_inc2 = {1'b0, idx_r} + (CNT_W+1)'(2);
  assign more_1   = idx_inc < count_r;
  assign more_2   = idx_inc2 < {1'b0, count_r};
  assign hit      = mem_rdata == val_r;
  assign accept   = req_valid && req_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      clis_pkg::ST_IDLE: begin
        if (req_valid) begin
          if ((req.op == clis_pkg::OP_REMOVE || req.op == clis_pkg::OP_SEARCH) &&
              count_r != '0) begin
            state_nxt = clis_pkg::ST_SCAN;
          end else begin
            state_nxt = clis_pkg::ST_DONE;
          end
        end
      end
      clis_pkg::ST_SCAN: begin
        if (hit) begin
          state_nxt = (op_r == clis_pkg::OP_SEARCH) ? clis_pkg::ST_DONE : clis_pkg::ST_SHIFT;
        end else if (!more_1) begin
          state_nxt = clis_pkg::ST_DONE;
        end
      end
      clis_pkg::ST_SHIFT: begin
        if (!more_1) begin
          state_nxt = clis_pkg::ST_DONE;
        end
      end
      clis_pkg::ST_DONE: begin
        if (res_taken) begin
          state_nxt = clis_pkg::ST_IDLE;
        end
      end
      default: state_nxt = clis_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    req_ready = 1'b0;
    res_valid = 1'b0;
    mem_wen   = 1'b0;
    mem_waddr = count_r[IDX_W-1:0];
    mem_wdata = req.value;
    mem_ren   = 1'b0;
    mem_raddr = '0;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    at_nxt    = at_r;
    op_nxt    = op_r;
    val_nxt   = val_r;
    res_nxt   = res_r;
    unique case (state_r)
      clis_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (accept) begin
          op_nxt  = req.op;
          val_nxt = req.value;
          idx_nxt = '0;
          res_nxt = '{status: clis_pkg::STAT_NOT_FOUND, position: '0,
                      fill_count: clis_pkg::FILL_W'(count_r)};
          unique case (req.op)
            clis_pkg::OP_INSERT: begin
              if (count_r >= CAP_CNT) begin
                res_nxt.status = clis_pkg::STAT_FULL;
              end else begin
                mem_wen   = 1'b1;
                count_nxt = count_r + CNT_W'(1);
                res_nxt   = '{status: clis_pkg::STAT_OK,
                              position: clis_pkg::POS_W'(count_r),
                              fill_count: clis_pkg::FILL_W'(count_nxt)};
              end
            end
            clis_pkg::OP_REMOVE, clis_pkg::OP_SEARCH: begin
              mem_ren = count_r != '0;
            end
            default: ;
          endcase
        end
      end
      clis_pkg::ST_SCAN: begin
        // read one ahead of the compare
        mem_ren   = more_1;
        mem_raddr = idx_inc[IDX_W-1:0];
        if (hit) begin
          at_nxt = idx_r[IDX_W-1:0];
          if (op_r == clis_pkg::OP_SEARCH) begin
            res_nxt = '{status: clis_pkg::STAT_OK, position: clis_pkg::POS_W'(idx_r),
                        fill_count: clis_pkg::FILL_W'(count_r)};
          end
        end else if (more_1) begin
          idx_nxt = idx_inc;
        end
      end
      clis_pkg::ST_SHIFT: begin
        // rdata holds entry idx + 1 here
        if (more_1) begin
          mem_wen   = 1'b1;
          mem_waddr = idx_r[IDX_W-1:0];
          mem_wdata = mem_rdata;
          mem_ren   = more_2;
          mem_raddr = idx_inc2[IDX_W-1:0];
          idx_nxt   = idx_inc;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          res_nxt   = '{status: clis_pkg::STAT_OK, position: clis_pkg::POS_W'(at_r),
                        fill_count: clis_pkg::FILL_W'(count_nxt)};
        end
      end
      clis_pkg::ST_DONE: begin
        res_valid = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= clis_pkg::ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    at_r  <= at_nxt;
    op_r  <= op_nxt;
    val_r <= val_nxt;
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule
